// File: rtl/pdm_pkg.sv
// ----------------------------------------------------------------------------
// pdm_pkg
// Shared constants, codes and types of the pairwise distance matrix block.
// ----------------------------------------------------------------------------
`default_nettype none

package pdm_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int WORD_W     = 2 * COORD_BITS;
    localparam int SUM_W      = 2 * COORD_BITS + 1;
    localparam int DIST_W     = COORD_BITS + 1;
    localparam int SQ_W       = SUM_W + 2;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    // Register map, indexed by word address.
    localparam logic REG_POINT_COUNT = 1'b0;

    // Item kinds.
    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_ROW   = 1'b1;

    // Sideband that travels with each column through the pipeline.
    typedef struct packed {
        logic [IDX_W-1:0] column;
        logic             last;
        logic             below;
    } t_tag;

endpackage

`default_nettype wire

// File: rtl/pairwise_distance_matrix.sv
// ----------------------------------------------------------------------------
// pairwise_distance_matrix
// Holds up to 64 points and streams rows of the upper-triangular Euclidean
// distance matrix, one column per cycle.
//
// Channel   Direction  Handshake                       Payload
// item      in         start high while busy low       i_kind, i_index,
//                                                      i_x_coord, i_y_coord
// result    out        o_valid strobe, one cycle each  o_distance, o_column,
//                                                      o_row_error, o_last
// config    in/out     APB, pready tied high           point_count at 0x0
//
// A row item with n points keeps busy high through one point memory read per
// column, then the difference, square, sum and a 17-stage root pipeline. A
// rejected row gives its single error result in the cycle after acceptance.
// Reset is synchronous, active low, and clears the control state; point
// memory contents stay undefined until written. Results cannot be stalled by
// the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module pairwise_distance_matrix (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_kind,
    input  wire logic [pdm_pkg::IDX_W-1:0]         i_index,
    input  wire logic [pdm_pkg::COORD_BITS-1:0]    i_x_coord,
    input  wire logic [pdm_pkg::COORD_BITS-1:0]    i_y_coord,
    output logic                                   o_valid,
    output logic      [pdm_pkg::DIST_W-1:0]        o_distance,
    output logic      [pdm_pkg::IDX_W-1:0]         o_column,
    output logic                                   o_row_error,
    output logic                                   o_last,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [pdm_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [pdm_pkg::DATA_W-1:0]        pwdata,
    output logic      [pdm_pkg::DATA_W-1:0]        prdata,
    output logic                                   pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROWPT,
        S_SCAN,
        S_DRAIN
    } t_state;

    t_state                         r_state;
    logic [pdm_pkg::CNT_W-1:0]      r_point_count;
    logic [pdm_pkg::IDX_W-1:0]      r_row;
    logic [pdm_pkg::IDX_W-1:0]      r_j;
    logic [pdm_pkg::COORD_BITS-1:0] r_xi;
    logic [pdm_pkg::COORD_BITS-1:0] r_yi;

    logic                           r_out_vld;
    logic [pdm_pkg::DIST_W-1:0]     r_out_dist;
    logic [pdm_pkg::IDX_W-1:0]      r_out_col;
    logic                           r_out_err;
    logic                           r_out_last;

    // Pipeline between the memory read and the root unit.
    logic                           r_va, r_vb, r_vc, r_vd;
    pdm_pkg::t_tag                  r_ta, r_tb, r_tc, r_td;
    logic [pdm_pkg::COORD_BITS-1:0] r_dx, r_dy;
    logic [pdm_pkg::WORD_W-1:0]     r_sqx, r_sqy;
    logic [pdm_pkg::SUM_W-1:0]      r_sum;

    logic [pdm_pkg::CNT_W-1:0]      eff_n;
    logic                           accept;
    logic                           idx_ok;
    logic                           row_reject;
    logic                           mem_we;
    logic [pdm_pkg::IDX_W-1:0]      rd_addr;
    logic [pdm_pkg::WORD_W-1:0]     rd_data;
    logic [pdm_pkg::COORD_BITS-1:0] rd_x, rd_y;
    logic                           last_col;
    logic                           cfg_we;
    logic                           sq_vld;
    logic [pdm_pkg::DIST_W-1:0]     sq_root;
    pdm_pkg::t_tag                  sq_tag;

    assign eff_n  = (r_point_count > pdm_pkg::CNT_W'(pdm_pkg::MAX_POINTS))
                  ? pdm_pkg::CNT_W'(pdm_pkg::MAX_POINTS) : r_point_count;
    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign idx_ok = (pdm_pkg::CNT_W'(i_index) < eff_n);
    assign mem_we = accept && (i_kind == pdm_pkg::KIND_STORE) && idx_ok;
    assign row_reject = accept && (i_kind == pdm_pkg::KIND_ROW) && !idx_ok;

    // While idle the port looks up the requested row's own point.
    assign rd_addr  = (r_state == S_IDLE) ? i_index : r_j;
    assign last_col = (pdm_pkg::CNT_W'(r_j) == (eff_n - pdm_pkg::CNT_W'(1)));

    pdm_point_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (i_index),
        .i_wdata ({i_x_coord, i_y_coord}),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign rd_x = rd_data[pdm_pkg::WORD_W-1:pdm_pkg::COORD_BITS];
    assign rd_y = rd_data[pdm_pkg::COORD_BITS-1:0];

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready
                  && (paddr[pdm_pkg::ADDR_W-1] == pdm_pkg::REG_POINT_COUNT);
    assign prdata = (paddr[pdm_pkg::ADDR_W-1] == pdm_pkg::REG_POINT_COUNT)
                  ? pdm_pkg::DATA_W'(r_point_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
        end else if (cfg_we) begin
            r_point_count <= pwdata[pdm_pkg::CNT_W-1:0];
        end
    end

    // Sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_vld  <= 1'b0;
            r_row      <= '0;
            r_j        <= '0;
            r_xi       <= '0;
            r_yi       <= '0;
            r_out_dist <= '0;
            r_out_col  <= '0;
            r_out_err  <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            if (row_reject) begin
                r_out_vld  <= 1'b1;
                r_out_dist <= '0;
                r_out_col  <= '0;
                r_out_err  <= 1'b1;
                r_out_last <= 1'b1;
            end else begin
                r_out_vld  <= sq_vld;
                r_out_dist <= sq_tag.below ? '0 : sq_root;
                r_out_col  <= sq_tag.column;
                r_out_err  <= 1'b0;
                r_out_last <= sq_tag.last;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_kind == pdm_pkg::KIND_ROW) && idx_ok) begin
                        r_row   <= i_index;
                        r_state <= S_ROWPT;
                    end
                end
                S_ROWPT: begin
                    r_xi    <= rd_x;
                    r_yi    <= rd_y;
                    r_j     <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (last_col) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_j <= r_j + pdm_pkg::IDX_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (sq_vld && sq_tag.last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            r_va <= (r_state == S_SCAN);
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ta.column <= r_j;
        r_ta.last   <= last_col;
        r_ta.below  <= (r_j < r_row);
        r_tb        <= r_ta;
        r_tc        <= r_tb;
        r_td        <= r_tc;
        r_dx        <= (r_xi >= rd_x) ? (r_xi - rd_x) : (rd_x - r_xi);
        r_dy        <= (r_yi >= rd_y) ? (r_yi - rd_y) : (rd_y - r_yi);
        r_sqx       <= pdm_pkg::WORD_W'(r_dx) * pdm_pkg::WORD_W'(r_dx);
        r_sqy       <= pdm_pkg::WORD_W'(r_dy) * pdm_pkg::WORD_W'(r_dy);
        r_sum       <= pdm_pkg::SUM_W'(r_sqx) + pdm_pkg::SUM_W'(r_sqy);
    end

    pdm_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vd),
        .i_sum   (r_sum),
        .i_tag   (r_td),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_tag   (sq_tag)
    );

    assign o_valid     = r_out_vld;
    assign o_distance  = r_out_dist;
    assign o_column    = r_out_col;
    assign o_row_error = r_out_err;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

// File: rtl/pdm_point_ram.sv
// ----------------------------------------------------------------------------
// pdm_point_ram
// Point memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pdm_point_ram (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [pdm_pkg::IDX_W-1:0]    i_waddr,
    input  wire logic [pdm_pkg::WORD_W-1:0]   i_wdata,
    input  wire logic [pdm_pkg::IDX_W-1:0]    i_raddr,
    output logic      [pdm_pkg::WORD_W-1:0]   o_rdata
);

    logic [pdm_pkg::WORD_W-1:0] r_mem [pdm_pkg::MAX_POINTS];
    logic [pdm_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/pdm_isqrt.sv
// ----------------------------------------------------------------------------
// pdm_isqrt
// Pipelined integer square root, one root bit per stage, with a tag that
// travels alongside each value.
// ----------------------------------------------------------------------------
`default_nettype none

module pdm_isqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [pdm_pkg::SUM_W-1:0]   i_sum,
    input  wire pdm_pkg::t_tag               i_tag,
    output logic                             o_valid,
    output logic      [pdm_pkg::DIST_W-1:0]  o_root,
    output pdm_pkg::t_tag                    o_tag
);

    logic [pdm_pkg::SQ_W-1:0]   r_rem  [pdm_pkg::DIST_W];
    logic [pdm_pkg::DIST_W-1:0] r_root [pdm_pkg::DIST_W];
    pdm_pkg::t_tag              r_tag  [pdm_pkg::DIST_W];
    logic [pdm_pkg::DIST_W-1:0] r_vld;

    for (genvar k = 0; k < pdm_pkg::DIST_W; k++) begin : g_stage
        localparam int B = pdm_pkg::DIST_W - 1 - k;

        logic [pdm_pkg::SQ_W-1:0]   rem_in;
        logic [pdm_pkg::SQ_W-1:0]   test;
        logic [pdm_pkg::DIST_W-1:0] root_in;
        pdm_pkg::t_tag              tag_in;
        logic                       vld_in;
        logic                       fits;

        if (k == 0) begin : g_first
            assign rem_in  = pdm_pkg::SQ_W'(i_sum);
            assign root_in = '0;
            assign tag_in  = i_tag;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign tag_in  = r_tag[k-1];
            assign vld_in  = r_vld[k-1];
        end

        // (q + 2^B)^2 - q^2 = q * 2^(B+1) + 2^(2B); rem holds s - q^2.
        assign test = (pdm_pkg::SQ_W'(root_in) << (B + 1))
                    + (pdm_pkg::SQ_W'(1) << (2 * B));
        assign fits = (rem_in >= test);

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= fits ? (rem_in - test) : rem_in;
            r_root[k] <= fits ? (root_in | (pdm_pkg::DIST_W'(1) << B)) : root_in;
            r_tag[k]  <= tag_in;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
        end
    end

    assign o_valid = r_vld[pdm_pkg::DIST_W-1];
    assign o_root  = r_root[pdm_pkg::DIST_W-1];
    assign o_tag   = r_tag[pdm_pkg::DIST_W-1];

endmodule

`default_nettype wire

// File: test/tb_pairwise_distance_matrix.sv
// ----------------------------------------------------------------------------
// tb_pairwise_distance_matrix
// Self-checking testbench: stores point sets, requests distance rows under
// several point counts and compares every result with a predicted matrix row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pairwise_distance_matrix;
    import pdm_pkg::*;

    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [IDX_W-1:0]  column;
        logic              row_error;
        logic              last;
    } t_distance_result;

    // Keeps a private copy of the point memory and the point count, and
    // queues the matrix row that each accepted item should produce.
    class distance_board;
        logic [COORD_BITS-1:0] x_points [MAX_POINTS];
        logic [COORD_BITS-1:0] y_points [MAX_POINTS];
        int unsigned           point_count;
        t_distance_result      pending_distances [$];
        int                    errors;

        function new();
            point_count = 0;
            errors      = 0;
        endfunction

        function void set_point_count(int unsigned value);
            point_count = value & 32'h7f;
        endfunction

        function int unsigned live_points();
            return (point_count > MAX_POINTS) ? MAX_POINTS : point_count;
        endfunction

        function logic [DIST_W-1:0] floor_sqrt(longint unsigned square);
            logic [DIST_W-1:0] root;
            logic [DIST_W-1:0] trial;
            root = '0;
            for (int b = DIST_W - 1; b >= 0; b--) begin
                trial = root | (DIST_W'(1) << b);
                if (64'(trial) * 64'(trial) <= square) begin
                    root = trial;
                end
            end
            return root;
        endfunction

        function void note_item(logic kind, logic [IDX_W-1:0] idx,
                                logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
            int unsigned      n;
            longint unsigned  dx;
            longint unsigned  dy;
            t_distance_result res;
            n = live_points();
            if (kind == KIND_STORE) begin
                if (idx < n) begin
                    x_points[idx] = x;
                    y_points[idx] = y;
                end
                return;
            end
            if (idx >= n) begin
                res = '{distance: '0, column: '0, row_error: 1'b1, last: 1'b1};
                pending_distances.push_back(res);
                return;
            end
            for (int unsigned j = 0; j < n; j++) begin
                res = '{distance: '0, column: IDX_W'(j), row_error: 1'b0,
                        last: (j == n - 1)};
                // Entries below the diagonal are reported as zero.
                if (j >= idx) begin
                    dx = (x_points[idx] >= x_points[j]) ? x_points[idx] - x_points[j]
                                                        : x_points[j] - x_points[idx];
                    dy = (y_points[idx] >= y_points[j]) ? y_points[idx] - y_points[j]
                                                        : y_points[j] - y_points[idx];
                    res.distance = floor_sqrt(dx * dx + dy * dy);
                end
                pending_distances.push_back(res);
            end
        endfunction

        function void check_result(t_distance_result got);
            t_distance_result want;
            if (pending_distances.size() == 0) begin
                $display("%0t: unexpected result distance=%0d column=%0d err=%0b last=%0b",
                         $time, got.distance, got.column, got.row_error, got.last);
                errors++;
                return;
            end
            want = pending_distances.pop_front();
            if (got.distance !== want.distance) begin
                $display("%0t: distance expected %0d actual %0d (column %0d)",
                         $time, want.distance, got.distance, want.column);
                errors++;
            end
            if (got.column !== want.column) begin
                $display("%0t: column expected %0d actual %0d",
                         $time, want.column, got.column);
                errors++;
            end
            if (got.row_error !== want.row_error) begin
                $display("%0t: row_error expected %0b actual %0b",
                         $time, want.row_error, got.row_error);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0b actual %0b (column %0d)",
                         $time, want.last, got.last, want.column);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    logic                  i_kind    = KIND_STORE;
    logic [IDX_W-1:0]      i_index   = '0;
    logic [COORD_BITS-1:0] i_x_coord = '0;
    logic [COORD_BITS-1:0] i_y_coord = '0;
    logic                  o_valid;
    logic [DIST_W-1:0]     o_distance;
    logic [IDX_W-1:0]      o_column;
    logic                  o_row_error;
    logic                  o_last;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [ADDR_W-1:0]     paddr     = '0;
    logic [DATA_W-1:0]     pwdata    = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    distance_board board = new();
    int            quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    pairwise_distance_matrix u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_index     (i_index),
        .i_x_coord   (i_x_coord),
        .i_y_coord   (i_y_coord),
        .o_valid     (o_valid),
        .o_distance  (o_distance),
        .o_column    (o_column),
        .o_row_error (o_row_error),
        .o_last      (o_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            board.check_result('{o_distance, o_column, o_row_error, o_last});
        end
    end

    // Any accepted item, result or register access counts as progress.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_pairwise_distance_matrix: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [COORD_BITS-1:0] rand_coord();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            return '0;
        end else if (pick < 20) begin
            return '1;
        end
        return COORD_BITS'($urandom);
    endfunction

    task automatic send_item(input logic kind, input logic [IDX_W-1:0] idx,
                             input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
        i_kind    <= kind;
        i_index   <= idx;
        i_x_coord <= x;
        i_y_coord <= y;
        start     <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) begin
            @(posedge i_clk);
        end
        board.note_item(kind, idx, x, y);
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (board.pending_distances.size() != 0 || busy !== 1'b0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_point_count(input int unsigned value);
        wait_results();
        // A store may still be in flight after the last result.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_POINT_COUNT, 2'b00};
        pwdata  <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        board.set_point_count(value);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[CNT_W-1:0] !== CNT_W'(value)) begin
            $display("%0t: point_count readback expected %0d actual %0d",
                     $time, value & 32'h7f, prdata[CNT_W-1:0]);
            board.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mixes stores and row requests; ignored stores do not count.
    task automatic run_traffic(input int target, input bit steady);
        int unsigned      n;
        int               counted;
        logic             kind;
        logic [IDX_W-1:0] idx;
        n       = board.live_points();
        counted = 0;
        while (counted < target) begin
            kind = ($urandom_range(0, 99) < 45) ? KIND_STORE : KIND_ROW;
            if (n > 0 && $urandom_range(0, 99) < 80) begin
                idx = IDX_W'($urandom_range(0, n - 1));
            end else begin
                idx = IDX_W'($urandom_range(0, MAX_POINTS - 1));
            end
            send_item(kind, idx, rand_coord(), rand_coord());
            if (kind == KIND_ROW || idx < n) begin
                counted++;
            end
            if (!steady && $urandom_range(0, 99) < 7) begin
                hold_off($urandom_range(1, 4));
            end
        end
    endtask

    initial begin
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty data set: every row is rejected and stores are dropped.
        send_item(KIND_ROW, 6'd0, '1, '0);
        send_item(KIND_ROW, 6'd63, '0, '1);
        send_item(KIND_STORE, 6'd5, '1, '1);

        // Fill every slot so that later rows never touch unwritten memory.
        write_point_count(64);
        for (int k = 0; k < MAX_POINTS; k++) begin
            case (k)
                0:       begin x = '0; y = '0; end
                1:       begin x = '1; y = '1; end
                62:      begin x = '0; y = '1; end
                63:      begin x = '1; y = '0; end
                default: begin x = COORD_BITS'($urandom); y = COORD_BITS'($urandom); end
            endcase
            send_item(KIND_STORE, IDX_W'(k), x, y);
            if ($urandom_range(0, 99) < 7) begin
                hold_off($urandom_range(1, 4));
            end
        end

        // Full rows, including the longest diagonal and the single-entry last row.
        send_item(KIND_ROW, 6'd0, '0, '0);
        send_item(KIND_ROW, 6'd1, '1, '1);
        send_item(KIND_ROW, 6'd62, '0, '0);
        send_item(KIND_ROW, 6'd63, '0, '0);
        send_item(KIND_STORE, 6'd63, 16'h8000, 16'h7fff);
        send_item(KIND_ROW, 6'd62, '1, '0);

        // A single point: one result that is both diagonal and last.
        write_point_count(1);
        send_item(KIND_ROW, 6'd0, '0, '0);
        send_item(KIND_ROW, 6'd1, '0, '0);
        send_item(KIND_STORE, 6'd1, '1, '1);
        send_item(KIND_ROW, 6'd63, '1, '1);

        write_point_count(64);
        run_traffic(30, 1'b0);
        wait_results();
        run_traffic(30, 1'b0);

        write_point_count(3);
        run_traffic(40, 1'b0);

        // Counts above capacity behave as a full set; no idling here.
        write_point_count(127);
        run_traffic(50, 1'b1);

        write_point_count(2);
        run_traffic(40, 1'b0);

        write_point_count($urandom_range(4, 16));
        run_traffic(30, 1'b0);

        write_point_count(0);
        run_traffic(15, 1'b0);

        write_point_count($urandom_range(65, 126));
        run_traffic(40, 1'b0);

        write_point_count($urandom_range(1, 63));
        run_traffic(50, 1'b0);

        write_point_count(1);
        run_traffic(20, 1'b0);

        write_point_count(64);
        run_traffic(20, 1'b0);

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending_distances.size() == 0) begin
            $display("tb_pairwise_distance_matrix: clean");
        end else begin
            $display("tb_pairwise_distance_matrix: errors");
        end
        $finish;
    end

endmodule
